>>> design/lpl_pkg.sv
// Package for the look-ahead peak limiter: field widths, register codes,
// reset values, controller states and the control structs between modules.
// No dependencies; every other design file imports it.
package lpl_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int GAIN_W    = 24;
    localparam int WLEN_W    = 9;
    localparam int CHAN_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;
    localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
    // Quotient bits of threshold * 2^23 / peak when peak exceeds threshold.
    localparam int DIV_STEPS = 23;
    localparam int DIV_CNT_W = 5;

    localparam logic [GAIN_W-1:0] UNITY_Q23   = 24'h800000;
    localparam logic [GAIN_W-1:0] THRESH_RST  = 24'h800000;
    localparam logic [GAIN_W-1:0] RELEASE_RST = 24'd175;
    localparam logic [WLEN_W-1:0] WINDOW_RST  = 9'd240;
    localparam logic [CHAN_W-1:0] ACTIVE_RST  = 2'd2;
    localparam logic [PROD_W-1:0] ROUND_HALF  = PROD_W'(1) << 22;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_RELEASE   = 2'd1,
        CFG_WINDOW    = 2'd2,
        CFG_ACTIVE    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_GAIN,
        ST_MUL_L,
        ST_MUL_R,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic scan_start;
    } t_pk_ctrl;

    typedef struct packed {
        logic rd_en;
        logic wr_left;
        logic wr_right;
    } t_dly_ctrl;

endpackage

>>> design/lpl_in_if.sv
// Input frame channel of the peak limiter: valid/ready plus one stereo frame.
// Depends on lpl_pkg for the sample width.
interface lpl_in_if import lpl_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;

    modport source (output valid, output in_left, output in_right, input ready);
    modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

>>> design/lpl_out_if.sv
// Result channel of the peak limiter: valid/ready plus the limited frame and gain.
// Depends on lpl_pkg for the sample and gain widths.
interface lpl_out_if import lpl_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic        [GAIN_W-1:0]   gain_now;

    modport source (output valid, output out_left, output out_right, output gain_now,
                    input ready);
    modport sink   (input valid, input out_left, input out_right, input gain_now,
                    output ready);
endinterface

>>> design/lpl_div.sv
// Serial restoring divider producing floor(num * 2^23 / den), one bit a cycle.
// Requires num < den. Depends on lpl_pkg.
module lpl_div import lpl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [GAIN_W-1:0] i_num,
    input  logic [GAIN_W-1:0] i_den,
    output logic              o_done,
    output logic [GAIN_W-1:0] o_quot
);

    logic                   r_busy;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [GAIN_W-1:0]      r_rem;
    logic [DIV_STEPS-1:0]   r_quo;
    logic [GAIN_W:0]        shifted;
    logic                   fits;

    // The remainder always stays below the divisor, so twice it fits in 25 bits.
    assign shifted = {r_rem, 1'b0};
    assign fits    = shifted >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_quo <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= fits ? GAIN_W'(shifted - {1'b0, i_den}) : GAIN_W'(shifted);
            r_quo <= {r_quo[DIV_STEPS-2:0], fits};
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = {1'b0, r_quo};

endmodule

>>> design/lpl_peak_scan.sv
// Peak history memory and the serial window scan that finds its maximum.
// One write port, one registered read port. Depends on lpl_pkg.
module lpl_peak_scan import lpl_pkg::*; #(
    parameter int MAX_WINDOW = 256,
    parameter int AW         = 8,
    parameter int LW         = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_pk_ctrl            i_ctrl,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [SAMPLE_W-1:0] i_wr_data,
    input  logic [LW-1:0]       i_len,
    output logic                o_done,
    output logic [SAMPLE_W-1:0] o_wpeak
);

    logic [SAMPLE_W-1:0] mem [MAX_WINDOW];
    logic [SAMPLE_W-1:0] r_rd_q;
    logic                r_busy;
    logic                r_rvld;
    logic [LW-1:0]       r_cnt;
    logic [SAMPLE_W-1:0] r_max;
    logic                rd_en;

    assign rd_en = r_busy && (r_cnt < i_len);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_q <= mem[r_cnt[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rvld <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctrl.scan_start) begin
            r_busy <= 1'b1;
            r_rvld <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rvld <= rd_en;
            if (rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.scan_start) begin
            r_max <= '0;
        end else if (r_rvld && r_rd_q > r_max) begin
            r_max <= r_rd_q;
        end
    end

    // Done once every entry has been read and the last read data folded in.
    assign o_done  = r_busy && !rd_en && !r_rvld;
    assign o_wpeak = r_max;

endmodule

>>> design/lpl_delay.sv
// Per-channel look-ahead delay memories, one read and one write per frame.
// The right channel memory exists only when two channels are built. Depends on lpl_pkg.
module lpl_delay import lpl_pkg::*; #(
    parameter int MAX_WINDOW = 256,
    parameter int CHANNELS   = 2,
    parameter int AW         = 8
) (
    input  logic                i_clk,
    input  t_dly_ctrl           i_ctrl,
    input  logic [AW-1:0]       i_addr,
    input  logic [SAMPLE_W-1:0] i_wr_left,
    input  logic [SAMPLE_W-1:0] i_wr_right,
    output logic [SAMPLE_W-1:0] o_rd_left,
    output logic [SAMPLE_W-1:0] o_rd_right
);

    logic [SAMPLE_W-1:0] mem_l [MAX_WINDOW];
    logic [SAMPLE_W-1:0] r_rd_l;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_left) begin
            mem_l[i_addr] <= i_wr_left;
        end
        if (i_ctrl.rd_en) begin
            r_rd_l <= mem_l[i_addr];
        end
    end

    assign o_rd_left = r_rd_l;

    if (CHANNELS >= 2) begin : g_right
        logic [SAMPLE_W-1:0] mem_r [MAX_WINDOW];
        logic [SAMPLE_W-1:0] r_rd_r;

        always_ff @(posedge i_clk) begin
            if (i_ctrl.wr_right) begin
                mem_r[i_addr] <= i_wr_right;
            end
            if (i_ctrl.rd_en) begin
                r_rd_r <= mem_r[i_addr];
            end
        end

        assign o_rd_right = r_rd_r;
    end else begin : g_no_right
        assign o_rd_right = '0;
    end

endmodule

>>> design/lookahead_peak_limiter.sv
// Top level of the look-ahead peak limiter: configuration registers, frame
// controller, gain update and shared gain multiplier. Depends on lpl_pkg,
// lpl_in_if, lpl_out_if, lpl_div, lpl_peak_scan and lpl_delay.
//
//   Channel    Dir  Handshake          Payload
//   i_frame    in   valid/ready        in_left, in_right (Q1.23)
//   o_frame    out  valid/ready        out_left, out_right (Q1.23), gain_now (Q23)
//   i_cfg_*    in   write enable only  register index, 24-bit data
//
// A frame's time is dominated by the serial scan of the peak memory through its single
// read port, over the clamped window length, and by the one-bit-a-cycle divider when
// a division is needed. One frame is in work at a time.
// After reset a clearing pass over all MAX_WINDOW addresses zeroes the peak and delay
// memories; no request is taken meanwhile, but configuration writes are. The result
// register lets the next request enter while a finished result still waits on o_frame.
module lookahead_peak_limiter import lpl_pkg::*; #(
    parameter int MAX_WINDOW = 256,
    parameter int CHANNELS   = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lpl_in_if.sink               i_frame,
    lpl_out_if.source            o_frame,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW = $clog2(MAX_WINDOW + 1);

    t_state r_state, n_state;

    logic [GAIN_W-1:0] r_thresh;
    logic [GAIN_W-1:0] r_release;
    logic [WLEN_W-1:0] r_window;
    logic [CHAN_W-1:0] r_active;

    logic [AW-1:0]       r_slot_idx;
    logic [AW-1:0]       r_clr_addr;
    logic [AW-1:0]       r_slot;
    logic [SAMPLE_W-1:0] r_in_l;
    logic [SAMPLE_W-1:0] r_in_r;
    logic                r_l_act;
    logic                r_r_act;
    logic [GAIN_W-1:0]   r_gain;
    logic [GAIN_W-1:0]   r_desired;
    logic [PROD_W-1:0]   r_prod;
    logic [SAMPLE_W-1:0] r_res_l;

    logic                r_out_vld;
    logic [SAMPLE_W-1:0] r_out_l;
    logic [SAMPLE_W-1:0] r_out_r;
    logic [GAIN_W-1:0]   r_out_g;

    logic [31:0]         len32;
    logic [LW-1:0]       len;
    logic [GAIN_W-1:0]   thr;
    logic                l_act;
    logic                right_act;
    logic [AW-1:0]       slot_c;
    logic [SAMPLE_W-1:0] abs_l;
    logic [SAMPLE_W-1:0] abs_r;
    logic [SAMPLE_W-1:0] peak_c;
    logic                accept;
    logic                out_free;
    logic                clr_last;
    logic [GAIN_W:0]     gain_up;
    logic [PROD_W-1:0]   prod_rnd;
    logic [SAMPLE_W-1:0] rounded;
    logic [SAMPLE_W-1:0] mul_src;

    t_pk_ctrl            pk_ctrl;
    t_dly_ctrl           dly_ctrl;
    logic [AW-1:0]       pk_addr;
    logic [SAMPLE_W-1:0] pk_data;
    logic [AW-1:0]       dly_addr;
    logic [SAMPLE_W-1:0] dly_wr_l;
    logic [SAMPLE_W-1:0] dly_wr_r;
    logic [SAMPLE_W-1:0] dly_rd_l;
    logic [SAMPLE_W-1:0] dly_rd_r;
    logic                scan_done;
    logic [SAMPLE_W-1:0] wpeak;
    logic                div_start;
    logic                div_done;
    logic [GAIN_W-1:0]   div_quot;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= THRESH_RST;
            r_release <= RELEASE_RST;
            r_window  <= WINDOW_RST;
            r_active  <= ACTIVE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD: r_thresh  <= i_cfg_data;
                CFG_RELEASE:   r_release <= i_cfg_data;
                CFG_WINDOW:    r_window  <= WLEN_W'(i_cfg_data);
                CFG_ACTIVE:    r_active  <= CHAN_W'(i_cfg_data);
                default:       r_thresh  <= r_thresh;
            endcase
        end
    end

    // Effective settings: window clamped to 1..MAX_WINDOW, threshold to unity.
    always_comb begin
        if (r_window == '0) begin
            len32 = 32'd1;
        end else if (32'(r_window) > 32'(MAX_WINDOW)) begin
            len32 = 32'(MAX_WINDOW);
        end else begin
            len32 = 32'(r_window);
        end
    end

    assign len       = len32[LW-1:0];
    assign thr       = (r_thresh > UNITY_Q23) ? UNITY_Q23 : r_thresh;
    assign l_act     = r_active >= 2'd1;
    assign right_act = (r_active >= 2'd2) && (CHANNELS >= 2);

    assign slot_c = (32'(r_slot_idx) >= 32'(len)) ? '0 : r_slot_idx;
    assign abs_l  = i_frame.in_left[SAMPLE_W-1]  ? SAMPLE_W'(-i_frame.in_left)
                                                 : SAMPLE_W'(i_frame.in_left);
    assign abs_r  = i_frame.in_right[SAMPLE_W-1] ? SAMPLE_W'(-i_frame.in_right)
                                                 : SAMPLE_W'(i_frame.in_right);

    always_comb begin
        peak_c = l_act ? abs_l : '0;
        if (right_act && abs_r > peak_c) begin
            peak_c = abs_r;
        end
    end

    assign i_frame.ready = (r_state == ST_IDLE);
    assign accept        = i_frame.valid && i_frame.ready;
    assign out_free      = !r_out_vld || o_frame.ready;
    assign clr_last      = (r_clr_addr == AW'(MAX_WINDOW - 1));

    // Controller: next state and memory strobes.
    always_comb begin
        n_state   = r_state;
        pk_ctrl   = '0;
        dly_ctrl  = '0;
        div_start = 1'b0;
        pk_addr   = slot_c;
        pk_data   = peak_c;
        dly_addr  = r_slot;
        dly_wr_l  = r_in_l;
        dly_wr_r  = r_in_r;
        unique case (r_state)
            ST_CLEAR: begin
                pk_ctrl.wr_en     = 1'b1;
                pk_addr           = r_clr_addr;
                pk_data           = '0;
                dly_ctrl.wr_left  = 1'b1;
                dly_ctrl.wr_right = 1'b1;
                dly_addr          = r_clr_addr;
                dly_wr_l          = '0;
                dly_wr_r          = '0;
                if (clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    pk_ctrl.wr_en      = 1'b1;
                    pk_ctrl.scan_start = 1'b1;
                    dly_ctrl.rd_en     = 1'b1;
                    dly_addr           = slot_c;
                    n_state            = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    div_start = wpeak > thr;
                    n_state   = (wpeak > thr) ? ST_DIV : ST_GAIN;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_GAIN;
                end
            end
            ST_GAIN:  n_state = ST_MUL_L;
            ST_MUL_L: n_state = ST_MUL_R;
            ST_MUL_R: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    dly_ctrl.wr_left  = r_l_act;
                    dly_ctrl.wr_right = r_r_act;
                    n_state           = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Clear address, slot pointer and gain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_slot_idx <= '0;
            r_gain     <= UNITY_Q23;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == ST_GAIN) begin
                if (r_desired < r_gain) begin
                    r_gain <= r_desired;
                end else begin
                    r_gain <= (gain_up < {1'b0, r_desired}) ? GAIN_W'(gain_up) : r_desired;
                end
            end
            if (r_state == ST_OUT && out_free) begin
                r_slot_idx <= (32'(r_slot) + 32'd1 >= 32'(len)) ? '0 : AW'(r_slot + 1'b1);
            end
        end
    end

    assign gain_up = {1'b0, r_gain} + {1'b0, r_release};

    // Shared gain multiplier: left sample first, right sample the cycle after.
    assign mul_src  = (r_state == ST_MUL_L) ? dly_rd_l : dly_rd_r;
    assign prod_rnd = r_prod + ROUND_HALF;
    assign rounded  = prod_rnd[SAMPLE_W+22:23];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_l  <= i_frame.in_left;
            r_in_r  <= i_frame.in_right;
            r_slot  <= slot_c;
            r_l_act <= l_act;
            r_r_act <= right_act;
        end
        if (r_state == ST_SCAN && scan_done) begin
            r_desired <= UNITY_Q23;
        end else if (r_state == ST_DIV && div_done) begin
            r_desired <= div_quot;
        end
        if (r_state == ST_MUL_L || r_state == ST_MUL_R) begin
            r_prod <= PROD_W'($signed(mul_src) * $signed({1'b0, r_gain}));
        end
        if (r_state == ST_MUL_R) begin
            r_res_l <= r_l_act ? rounded : r_in_l;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_out_l <= r_res_l;
            r_out_r <= r_r_act ? rounded : r_in_r;
            r_out_g <= r_gain;
        end
    end

    assign o_frame.valid     = r_out_vld;
    assign o_frame.out_left  = r_out_l;
    assign o_frame.out_right = r_out_r;
    assign o_frame.gain_now  = r_out_g;

    lpl_peak_scan #(
        .MAX_WINDOW (MAX_WINDOW),
        .AW         (AW),
        .LW         (LW)
    ) u_peak (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (pk_ctrl),
        .i_wr_addr  (pk_addr),
        .i_wr_data  (pk_data),
        .i_len      (len),
        .o_done     (scan_done),
        .o_wpeak    (wpeak)
    );

    lpl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_num      (thr),
        .i_den      (wpeak),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    lpl_delay #(
        .MAX_WINDOW (MAX_WINDOW),
        .CHANNELS   (CHANNELS),
        .AW         (AW)
    ) u_delay (
        .i_clk      (i_clk),
        .i_ctrl     (dly_ctrl),
        .i_addr     (dly_addr),
        .i_wr_left  (dly_wr_l),
        .i_wr_right (dly_wr_r),
        .o_rd_left  (dly_rd_l),
        .o_rd_right (dly_rd_r)
    );

endmodule
